// ===== hdl/pcb_pkg.sv =====
// pcb_pkg: shared types and constants of the Huffman code bit packer.
// No dependencies.
package pcb_pkg;

  localparam int CODE_W   = 24;  // width of a code word
  localparam int LEN_W    = 5;   // width of a code length
  localparam int SYM_W    = 8;
  localparam int NUM_SYMS = 256;
  localparam int BYTE_W   = 8;
  localparam int FILL_W   = 3;
  localparam int QDEPTH   = 4;   // front-to-back queue entries
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ENCODE = 2'd0,
    KIND_MISS   = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  // work item handed from the front end to the packer
  typedef struct packed {
    kind_t              kind;
    logic [LEN_W-1:0]   len;
    logic [CODE_W-1:0]  code;
  } item_t;

  // queue status seen by the front end and the packer
  typedef struct packed {
    logic              not_empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic [2:0]        pad_count;
    logic              flush_done;
    logic              missing_code;
    logic              last;
  } result_t;

endpackage

// ===== hdl/pcb_in_if.sv =====
// pcb_in_if: input transaction channel of the bit packer.
// Depends on nothing.
interface pcb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  symbol;
  logic [23:0] code_word;
  logic [4:0]  code_length;

  modport source (output valid, command, symbol, code_word, code_length, input ready);
  modport sink   (input valid, command, symbol, code_word, code_length, output ready);
endinterface

// ===== hdl/pcb_out_if.sv =====
// pcb_out_if: result transaction channel of the bit packer.
// Depends on nothing.
interface pcb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [2:0] pad_count;
  logic       flush_done;
  logic       missing_code;
  logic       last;

  modport source (output valid, out_byte, byte_valid, pad_count, flush_done, missing_code,
                  last, input ready);
  modport sink   (input valid, out_byte, byte_valid, pad_count, flush_done, missing_code,
                  last, output ready);
endinterface

// ===== hdl/pcb_ram.sv =====
// pcb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcb_ram #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/pcb_front.sv =====
// pcb_front: accepts transactions, writes the code table, looks up symbols
// and pushes classified work into the queue. Uses pcb_pkg, pcb_in_if, pcb_ram.
module pcb_front #(
  parameter int MAX_CODE_LEN = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  pcb_in_if.sink            in_ch,
  input  pcb_pkg::q_status_t q_stat,
  output logic              push,
  output pcb_pkg::item_t    push_item
);

  localparam int LEN_LIMIT = (MAX_CODE_LEN < pcb_pkg::CODE_W) ? MAX_CODE_LEN
                                                               : pcb_pkg::CODE_W;

  logic                          accept;
  logic [pcb_pkg::NUM_SYMS-1:0]  entry_valid_r;
  logic                          s1_valid_r, s1_valid_nxt;
  pcb_pkg::kind_t                s1_kind_r, s1_kind_nxt;
  logic                          load_we;
  logic [pcb_pkg::LEN_W-1:0]     len_sat;
  logic [pcb_pkg::CODE_W-1:0]    code_mask;
  logic [pcb_pkg::LEN_W+pcb_pkg::CODE_W-1:0] rd_entry;

  // one transaction in flight between accept and push is counted as a credit
  assign in_ch.ready = ({1'b0, q_stat.count} + {{pcb_pkg::QCNT_W{1'b0}}, s1_valid_r})
                       < (pcb_pkg::QCNT_W+1)'(pcb_pkg::QDEPTH);
  assign accept = in_ch.valid && in_ch.ready;

  assign len_sat   = (in_ch.code_length > pcb_pkg::LEN_W'(LEN_LIMIT))
                     ? pcb_pkg::LEN_W'(LEN_LIMIT) : in_ch.code_length;
  assign code_mask = ~({pcb_pkg::CODE_W{1'b1}} << len_sat);
  assign load_we   = accept && (in_ch.command == pcb_pkg::CMD_LOAD);

  always_comb begin
    s1_valid_nxt = 1'b0;
    s1_kind_nxt  = pcb_pkg::KIND_FLUSH;
    if (accept) begin
      unique case (in_ch.command)
        pcb_pkg::CMD_ENCODE: begin
          s1_valid_nxt = 1'b1;
          s1_kind_nxt  = entry_valid_r[in_ch.symbol] ? pcb_pkg::KIND_ENCODE
                                                     : pcb_pkg::KIND_MISS;
        end
        pcb_pkg::CMD_FLUSH: begin
          s1_valid_nxt = 1'b1;
          s1_kind_nxt  = pcb_pkg::KIND_FLUSH;
        end
        default: begin
          s1_valid_nxt = 1'b0;  // loads finish here; unused command dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
      s1_valid_r    <= 1'b0;
      s1_kind_r     <= pcb_pkg::KIND_FLUSH;
    end else begin
      if (load_we) begin
        entry_valid_r[in_ch.symbol] <= 1'b1;
      end
      s1_valid_r <= s1_valid_nxt;
      s1_kind_r  <= s1_kind_nxt;
    end
  end

  pcb_ram #(
    .WIDTH (pcb_pkg::LEN_W + pcb_pkg::CODE_W),
    .DEPTH (pcb_pkg::NUM_SYMS)
  ) u_code_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_ch.symbol),
    .wdata ({len_sat, in_ch.code_word & code_mask}),
    .raddr (in_ch.symbol),
    .rdata (rd_entry)
  );

  assign push           = s1_valid_r;
  assign push_item.kind = s1_kind_r;
  assign push_item.len  = rd_entry[pcb_pkg::LEN_W+pcb_pkg::CODE_W-1:pcb_pkg::CODE_W];
  assign push_item.code = rd_entry[pcb_pkg::CODE_W-1:0];

endmodule

// ===== hdl/pcb_queue.sv =====
// pcb_queue: small flop-based FIFO between front end and packer.
// Uses pcb_pkg.
module pcb_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pcb_pkg::item_t     push_item,
  input  logic               pop,
  output pcb_pkg::item_t     head,
  output pcb_pkg::q_status_t q_stat
);

  pcb_pkg::item_t              q_r [pcb_pkg::QDEPTH];
  logic [pcb_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [pcb_pkg::QCNT_W-1:0]  count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  assign head             = q_r[rd_ptr_r];
  assign q_stat.count     = count_r;
  assign q_stat.not_empty = (count_r != '0);

endmodule

// ===== hdl/pcb_back.sv =====
// pcb_back: bit packer. Pops work items, merges code bits into the byte
// accumulator and drives the result register. Uses pcb_pkg, pcb_out_if.
module pcb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pcb_pkg::item_t     head,
  input  pcb_pkg::q_status_t q_stat,
  output logic               pop,
  pcb_out_if.source          out_ch
);

  logic [pcb_pkg::BYTE_W-1:0] acc_r, acc_nxt;
  logic [pcb_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic                       busy_r, busy_nxt;
  logic [1:0]                 n_r, n_nxt, k_r, k_nxt;
  logic [15:0]                tail_r, tail_nxt;   // bytes 1 and 2 of a long code
  logic                       out_valid_r, out_valid_nxt;
  pcb_pkg::result_t           res_r, res_nxt;

  logic                         slot_free;
  logic [pcb_pkg::CODE_W-1:0]   code_al;
  logic [31:0]                  win;
  logic [pcb_pkg::LEN_W-1:0]    total;
  logic [1:0]                   nbytes;
  logic [pcb_pkg::BYTE_W-1:0]   rest_byte;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign pop       = q_stat.not_empty && !busy_r && slot_free;

  // left-align the code, then drop it in right after the pending bits
  assign code_al = head.code << (pcb_pkg::LEN_W'(pcb_pkg::CODE_W) - head.len);
  assign win     = {acc_r, 24'd0} | ({code_al, 8'd0} >> fill_r);
  assign total   = pcb_pkg::LEN_W'(fill_r) + head.len;
  assign nbytes  = total[4:3];

  always_comb begin
    unique case (nbytes)
      2'd0:    rest_byte = win[31:24];
      2'd1:    rest_byte = win[23:16];
      2'd2:    rest_byte = win[15:8];
      default: rest_byte = win[7:0];
    endcase
  end

  always_comb begin
    acc_nxt       = acc_r;
    fill_nxt      = fill_r;
    busy_nxt      = busy_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    tail_nxt      = tail_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (busy_r && slot_free) begin
      out_valid_nxt      = 1'b1;
      res_nxt            = '0;
      res_nxt.out_byte   = (k_r == 2'd1) ? tail_r[15:8] : tail_r[7:0];
      res_nxt.byte_valid = 1'b1;
      res_nxt.last       = (k_r + 2'd1 == n_r);
      busy_nxt           = (k_r + 2'd1 != n_r);
      k_nxt              = k_r + 2'd1;
    end else if (pop) begin
      res_nxt = '0;
      unique case (head.kind)
        pcb_pkg::KIND_MISS: begin
          out_valid_nxt        = 1'b1;
          res_nxt.missing_code = 1'b1;
          res_nxt.last         = 1'b1;
        end
        pcb_pkg::KIND_FLUSH: begin
          out_valid_nxt      = 1'b1;
          res_nxt.flush_done = 1'b1;
          res_nxt.last       = 1'b1;
          if (fill_r != '0) begin
            res_nxt.out_byte   = acc_r;
            res_nxt.byte_valid = 1'b1;
            res_nxt.pad_count  = 3'(4'd8 - {1'b0, fill_r});
          end
          acc_nxt  = '0;
          fill_nxt = '0;
        end
        pcb_pkg::KIND_ENCODE: begin
          acc_nxt  = rest_byte;
          fill_nxt = total[2:0];
          if (nbytes != 2'd0) begin
            out_valid_nxt      = 1'b1;
            res_nxt.out_byte   = win[31:24];
            res_nxt.byte_valid = 1'b1;
            res_nxt.last       = (nbytes == 2'd1);
          end
          if (nbytes > 2'd1) begin
            busy_nxt = 1'b1;
            n_nxt    = nbytes;
            k_nxt    = 2'd1;
            tail_nxt = win[23:8];
          end
        end
        default: begin
          out_valid_nxt = out_valid_r && !out_ch.ready;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      fill_r      <= '0;
      busy_r      <= 1'b0;
      n_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      fill_r      <= fill_nxt;
      busy_r      <= busy_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_r <= tail_nxt;
    res_r  <= res_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = res_r.out_byte;
  assign out_ch.byte_valid   = res_r.byte_valid;
  assign out_ch.pad_count    = res_r.pad_count;
  assign out_ch.flush_done   = res_r.flush_done;
  assign out_ch.missing_code = res_r.missing_code;
  assign out_ch.last         = res_r.last;

endmodule

// ===== hdl/huffman_code_bit_packer.sv =====
// Huffman code bit packer: 256-entry code table plus a byte-wide bit packer.
// Path: an encode or flush transaction passes the lookup register and the queue, then the
//   result register; a load takes effect for any transaction accepted after it.
// Throughput: one transaction per clock at the input while queue credits last; the packer
//   emits one result per clock while out_ch.ready holds; loads take no packer time.
// Reset (rst_n, synchronous): clears table valid marks, accumulator, queue and output; the
//   code RAM itself is not cleared, so the block is ready the clock after reset.
module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = 24
) (
  input logic       clk,
  input logic       rst_n,
  pcb_in_if.sink    in_ch,
  pcb_out_if.source out_ch
);

  // Front end: accept, load the code RAM, look up the symbol's valid mark,
  // and in the following clock push {kind, length, code} into the queue. The ready
  // credit counts the transaction sitting in the lookup stage.
  logic               push;
  pcb_pkg::item_t     push_item;
  logic               pop;
  pcb_pkg::item_t     head;
  pcb_pkg::q_status_t q_stat;

  pcb_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // Queue decouples lookups from byte emission, so input keeps flowing until
  // the queue fills while a long code drains bytes or the result side stalls.
  pcb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Packer: merges code bits into the accumulator and owns the result
  // register, which is refilled in the same clock it is taken.
  pcb_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // credit scheme must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> q_stat.count < pcb_pkg::QCNT_W'(pcb_pkg::QDEPTH))
    else $error("queue overflow");

  // packer never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.not_empty)
    else $error("pop from empty queue");

  // a missing-code result carries no byte and closes its transaction
  a_miss_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.missing_code |-> !out_ch.byte_valid && out_ch.last
                                            && !out_ch.flush_done)
    else $error("malformed missing-code result");

endmodule
